// File: sv/tsee_pkg.sv
`timescale 1ns / 1ps

package tsee_pkg;

   localparam int NUM_BITS   = 12;
   localparam int NUM_EVENTS = 2 * NUM_BITS;
   localparam int NUM_THR    = 6;

   typedef logic [NUM_BITS-1:0]   flags_type;
   typedef logic [NUM_EVENTS-1:0] events_type;

   // item kinds
   localparam logic KIND_UPDATE = 1'b0;
   localparam logic KIND_REARM  = 1'b1;

   // register indexes
   localparam logic [2:0] REG_LNC  = 3'd0;
   localparam logic [2:0] REG_LCR  = 3'd1;
   localparam logic [2:0] REG_LNR  = 3'd2;
   localparam logic [2:0] REG_UNC  = 3'd3;
   localparam logic [2:0] REG_UCR  = 3'd4;
   localparam logic [2:0] REG_UNR  = 3'd5;
   localparam logic [2:0] REG_HYST = 3'd6;
   localparam logic [2:0] REG_EN   = 3'd7;

   localparam logic [7:0] THR_LOWER_RESET = 8'h00;
   localparam logic [7:0] THR_UPPER_RESET = 8'hFF;

   typedef struct packed {
      logic       kind;
      logic [7:0] reading;
      logic       valid;
      logic       ctx;
      flags_type  force_as;
      flags_type  force_de;
   } req_item_type;

endpackage

// File: sv/threshold_sensor_event_engine_top.sv
`timescale 1ns / 1ps

// an accepted item is registered in the input register, then moves into the 24-bit
//   pending mask of the emitter, which gives one event per cycle while the receiver is
//   ready, up to 24 events per item; the next item loads once the mask is empty or its last event is taken
// reset: synchronous, active high; clears state flags, thresholds, hysteresis and
//   enables to their defaults and drops any item in flight
module threshold_sensor_event_engine_top (
   input  logic        clock,
   input  logic        reset,
   // input item channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] reading_value, [8] reading_valid, [9] sensor_ctx,
   // [21:10] force_assert_mask, [33:22] force_deassert_mask, [39:34] zero
   input  logic [39:0] req_tdata,
   // [0] kind
   input  logic        req_tuser,
   // event channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [3:0] event_offset, [11:4] event_reading, [19:12] event_threshold,
   // [31:20] active_now
   output logic [31:0] rsp_tdata,
   // [0] is_assertion
   output logic        rsp_tuser,
   output logic        rsp_tlast,
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);
   import tsee_pkg::*;

   // ---------------- configuration registers ----------------
   logic [7:0]  thr_ff [NUM_THR];
   logic [7:0]  hyst_lo_ff;
   logic [7:0]  hyst_hi_ff;
   flags_type   en_as_ff;
   flags_type   en_de_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_THR; i++) begin
            thr_ff[i] <= (i < 3) ? THR_LOWER_RESET : THR_UPPER_RESET;
         end
         hyst_lo_ff <= '0;
         hyst_hi_ff <= '0;
         en_as_ff   <= '0;
         en_de_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_LNC:  thr_ff[0] <= csr_data[7:0];
            REG_LCR:  thr_ff[1] <= csr_data[7:0];
            REG_LNR:  thr_ff[2] <= csr_data[7:0];
            REG_UNC:  thr_ff[3] <= csr_data[7:0];
            REG_UCR:  thr_ff[4] <= csr_data[7:0];
            REG_UNR:  thr_ff[5] <= csr_data[7:0];
            REG_HYST: begin
               hyst_lo_ff <= csr_data[7:0];
               hyst_hi_ff <= csr_data[15:8];
            end
            REG_EN: begin
               en_as_ff <= csr_data[11:0];
               en_de_ff <= csr_data[23:12];
            end
            default: ;
         endcase
      end
   end

   // ---------------- input register ----------------
   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         load;         // input register moves into the emitter

   assign req_tready = !in_valid_ff || load;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.kind     <= req_tuser;
         in_item_ff.reading  <= req_tdata[7:0];
         in_item_ff.valid    <= req_tdata[8];
         in_item_ff.ctx      <= req_tdata[9];
         in_item_ff.force_as <= req_tdata[21:10];
         in_item_ff.force_de <= req_tdata[33:22];
      end
   end

   // ---------------- threshold evaluation ----------------
   // per bit: odd bits go high (upper side hysteresis), even bits go low
   flags_type  active_ff;
   flags_type  active_in;
   events_type events_in;
   logic       update_ok;

   assign update_ok = (in_item_ff.kind == KIND_UPDATE) && in_item_ff.valid && in_item_ff.ctx;

   always_comb begin
      logic [7:0] t;
      logic [8:0] sum;
      logic       as_raw;
      logic       de_raw;
      logic       as_eff;
      logic       de_eff;
      active_in = active_ff;
      events_in = '0;
      for (int b = 0; b < NUM_BITS; b++) begin
         t = thr_ff[3'(b / 2)];
         if (b % 2 == 1) begin
            sum    = {1'b0, in_item_ff.reading} + {1'b0, hyst_hi_ff};
            as_raw = in_item_ff.reading >= t;
            de_raw = sum < {1'b0, t};
         end else begin
            sum    = {1'b0, t} + {1'b0, hyst_lo_ff};
            as_raw = in_item_ff.reading <= t;
            de_raw = {1'b0, in_item_ff.reading} > sum;
         end
         as_eff = as_raw && !active_ff[b];
         de_eff = de_raw &&  active_ff[b];
         if (as_eff) active_in[b] = 1'b1;
         if (de_eff) active_in[b] = 1'b0;
         // deassertion first, then assertion, per bit
         events_in[2*b]   = (de_eff || in_item_ff.force_de[b]) && en_de_ff[b];
         events_in[2*b+1] = (as_eff || in_item_ff.force_as[b]) && en_as_ff[b];
      end
      if (!update_ok) begin
         events_in = '0;
         active_in = (in_item_ff.kind == KIND_REARM) ? '0 : active_ff;
      end
   end

   // ---------------- event emitter ----------------
   events_type pend_ff;
   logic [7:0] rd_ff;
   flags_type  now_ff;
   events_type pend_rest;     // pending mask without the current event
   logic [4:0] first_idx;
   logic       emit_done;     // emitter is free for a load this cycle

   always_comb begin
      first_idx = '0;
      for (int i = NUM_EVENTS - 1; i >= 0; i--) begin
         if (pend_ff[i]) first_idx = 5'(i);
      end
   end

   assign pend_rest = pend_ff & (pend_ff - events_type'(1));
   assign emit_done = (pend_ff == '0) || (rsp_tready && pend_rest == '0);
   assign load      = in_valid_ff && emit_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff   <= '0;
         active_ff <= '0;
      end else if (load) begin
         pend_ff   <= events_in;
         active_ff <= active_in;
      end else if (rsp_tvalid && rsp_tready) begin
         pend_ff   <= pend_rest;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rd_ff  <= in_item_ff.reading;
         now_ff <= active_in;
      end
   end

   // threshold of the current event
   logic [3:0] offset;
   logic [7:0] thr_sel;

   assign offset = first_idx[4:1];

   always_comb begin
      case (offset[3:1])
         3'd0:    thr_sel = thr_ff[0];
         3'd1:    thr_sel = thr_ff[1];
         3'd2:    thr_sel = thr_ff[2];
         3'd3:    thr_sel = thr_ff[3];
         3'd4:    thr_sel = thr_ff[4];
         3'd5:    thr_sel = thr_ff[5];
         default: thr_sel = '0;
      endcase
   end

   assign rsp_tvalid = (pend_ff != '0);
   assign rsp_tdata  = {now_ff, thr_sel, rd_ff, offset};
   assign rsp_tuser  = first_idx[0];
   assign rsp_tlast  = (pend_rest == '0);

   // ---------------- assertions ----------------
   property p_offset_range;
      @(posedge clock) disable iff (reset) rsp_tvalid |-> (offset <= 4'd11);
   endproperty
   a_offset_range: assert property (p_offset_range) else $error("event offset out of range");

   property p_stall_holds;
      @(posedge clock) disable iff (reset)
         (rsp_tvalid && !rsp_tready) |=> $stable(pend_ff) && $stable(now_ff);
   endproperty
   a_stall_holds: assert property (p_stall_holds) else $error("pending events moved on stall");

   property p_rearm_clears;
      @(posedge clock) disable iff (reset)
         (load && in_item_ff.kind == KIND_REARM) |=> (active_ff == '0) && !rsp_tvalid;
   endproperty
   a_rearm_clears: assert property (p_rearm_clears) else $error("rearm left state or events");

   property p_no_update_keeps;
      @(posedge clock) disable iff (reset)
         (load && in_item_ff.kind == KIND_UPDATE && !(in_item_ff.valid && in_item_ff.ctx))
         |=> $stable(active_ff) && !rsp_tvalid;
   endproperty
   a_no_update_keeps: assert property (p_no_update_keeps) else $error("ignored reading changed state");

endmodule

// File: bench/threshold_sensor_event_engine_top_test.sv
`timescale 1ns / 1ps

module threshold_sensor_event_engine_top_test;
   import tsee_pkg::*;

   // cycle budget, far above the slowest correct run
   localparam int CYCLE_LIMIT = 600000;
   // cycles to let the emitter settle once nothing is owed
   localparam int SETTLE_CYCLES = 8;
   localparam int ITEMS_PER_PHASE = 108;
   localparam int ITEMS_PER_SETTING = 36;

   // one event on the result channel
   typedef struct packed {
      logic       is_assertion;
      logic [3:0] offset;
      logic [7:0] reading;
      logic [7:0] threshold;
      flags_type  active_now;
      logic       last;
   } sensor_event_type;

   // shadow of the threshold logic plus the events still owed by the block
   class event_ledger;
      logic [7:0]       thr[NUM_THR];
      logic [7:0]       hyst_high;
      logic [7:0]       hyst_low;
      logic [23:0]      enables;
      flags_type        active;
      sensor_event_type owed_events[$];
      int               errors;

      function new();
         for (int i = 0; i < NUM_THR; i++) begin
            thr[i] = (i < 3) ? THR_LOWER_RESET : THR_UPPER_RESET;
         end
         hyst_high = '0;
         hyst_low  = '0;
         enables   = '0;
         active    = '0;
         errors    = 0;
      endfunction

      function int owed();
         return owed_events.size();
      endfunction

      function void write_reg(logic [2:0] idx, logic [23:0] val);
         case (idx)
            REG_HYST: begin
               hyst_high = val[15:8];
               hyst_low  = val[7:0];
            end
            REG_EN: begin
               enables = val;
            end
            default: begin
               thr[idx] = val[7:0];
            end
         endcase
      endfunction

      // work out the events of one accepted item and update the flags
      function void predict_events(logic kind, logic [39:0] data);
         int               v;
         int               t;
         bit               rise;
         bit               fall;
         flags_type        fa;
         flags_type        fd;
         sensor_event_type ev;
         sensor_event_type batch[$];

         v  = data[7:0];
         fa = data[21:10];
         fd = data[33:22];
         if (kind == KIND_REARM) begin
            active = '0;
            return;
         end
         // no reading or out of context: nothing happens
         if (data[8] !== 1'b1 || data[9] !== 1'b1) begin
            return;
         end
         for (int b = 0; b < NUM_BITS; b++) begin
            t = thr[b / 2];
            if (b % 2 == 1) begin
               // going-high bit
               rise = (v >= t);
               fall = (v + int'(hyst_high) < t);
            end else begin
               // going-low bit
               rise = (v <= t);
               fall = (v > t + int'(hyst_low));
            end
            if (active[b]) begin
               rise = 1'b0;
            end else begin
               fall = 1'b0;
            end
            if (rise) begin
               active[b] = 1'b1;
            end
            if (fall) begin
               active[b] = 1'b0;
            end
            ev.offset    = 4'(b);
            ev.reading   = 8'(v);
            ev.threshold = 8'(t);
            ev.active_now = '0;
            ev.last      = 1'b0;
            // deassertion comes before assertion for the same bit
            if ((fall || fd[b]) && enables[NUM_BITS + b]) begin
               ev.is_assertion = 1'b0;
               batch.insert(batch.size(), ev);
            end
            if ((rise || fa[b]) && enables[b]) begin
               ev.is_assertion = 1'b1;
               batch.insert(batch.size(), ev);
            end
         end
         foreach (batch[k]) begin
            batch[k].active_now = active;
            batch[k].last = (k == batch.size() - 1);
            owed_events.insert(owed_events.size(), batch[k]);
         end
      endfunction

      task report(string msg);
         $display("[%0t] event mismatch: %s", $realtime, msg);
         errors++;
      endtask

      task check_event(logic is_as, logic [31:0] data, logic last);
         sensor_event_type want;

         if (owed_events.size() == 0) begin
            report($sformatf("event with nothing owed, offset %0d", data[3:0]));
            return;
         end
         want = owed_events.pop_front();
         if (is_as !== want.is_assertion) begin
            report($sformatf("is_assertion %b, wanted %b (offset %0d)",
                             is_as, want.is_assertion, want.offset));
         end
         if (data[3:0] !== want.offset) begin
            report($sformatf("offset %0d, wanted %0d", data[3:0], want.offset));
         end
         if (data[11:4] !== want.reading) begin
            report($sformatf("reading %0d, wanted %0d", data[11:4], want.reading));
         end
         if (data[19:12] !== want.threshold) begin
            report($sformatf("threshold %0d, wanted %0d (offset %0d)",
                             data[19:12], want.threshold, want.offset));
         end
         if (data[31:20] !== want.active_now) begin
            report($sformatf("active_now %h, wanted %h", data[31:20], want.active_now));
         end
         if (last !== want.last) begin
            report($sformatf("last %b, wanted %b (offset %0d)", last, want.last,
                             want.offset));
         end
      endtask
   endclass

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;
   logic        req_tuser  = KIND_UPDATE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index  = REG_LNC;
   logic [23:0] csr_data   = '0;

   // idle percentages of sender and receiver, changed per phase
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int          cycles        = 0;

   // settings the stimulus is about to load
   logic [7:0]  thr_set[NUM_THR];
   logic [15:0] hyst_set;
   logic [23:0] en_set;

   event_ledger ledger = new();

   threshold_sensor_event_engine_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // receiver stalls at random
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // watch all three channels; values read here are the pre-edge ones
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            ledger.write_reg(csr_index, csr_data);
         end
         if (req_tvalid && req_tready) begin
            ledger.predict_events(req_tuser, req_tdata);
         end
         if (rsp_tvalid === 1'b1 && rsp_tready) begin
            ledger.check_event(rsp_tuser, rsp_tdata, rsp_tlast);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("threshold_sensor_event_engine_top_test: FAIL");
         $finish;
      end
   end

   function automatic req_item_type make_item(logic kind, logic [7:0] rd, logic ok,
                                              logic ctx, flags_type fa, flags_type fd);
      req_item_type it;

      it.kind     = kind;
      it.reading  = rd;
      it.valid    = ok;
      it.ctx      = ctx;
      it.force_as = fa;
      it.force_de = fd;
      return it;
   endfunction

   task automatic send_item(req_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.kind;
      req_tdata  <= {6'b0, it.force_de, it.force_as, it.ctx, it.valid, it.reading};
      do @(posedge clock); while (req_tready !== 1'b1);
   endtask

   task automatic send_update(logic [7:0] rd);
      send_item(make_item(KIND_UPDATE, rd, 1'b1, 1'b1, '0, '0));
   endtask

   // stop sending and let every owed event drain, then let the emitter settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (ledger.owed() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [23:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
   endtask

   // load every register while the block is idle
   task automatic apply_config();
      wait_idle();
      for (int i = 0; i < NUM_THR; i++) begin
         write_reg(REG_LNC + 3'(i), {16'b0, thr_set[i]});
      end
      write_reg(REG_HYST, {8'b0, hyst_set});
      write_reg(REG_EN, en_set);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_all_thresholds(logic [7:0] lower, logic [7:0] upper);
      for (int i = 0; i < NUM_THR; i++) begin
         thr_set[i] = (i < 3) ? lower : upper;
      end
   endtask

   // pick a new setting: mostly ordered thresholds, sometimes extremes or noise
   task automatic new_settings();
      case ($urandom_range(7))
         0: begin
            set_all_thresholds(8'h00, 8'h00);
            hyst_set = 16'hFFFF;
            en_set   = 24'hFFFFFF;
         end
         1: begin
            set_all_thresholds(8'hFF, 8'hFF);
            hyst_set = 16'h0000;
            en_set   = 24'hFFFFFF;
         end
         2: begin
            for (int i = 0; i < NUM_THR; i++) begin
               thr_set[i] = 8'($urandom_range(255));
            end
            hyst_set = 16'($urandom_range(65535));
            en_set   = 24'($urandom);
         end
         default: begin
            thr_set[REG_LNR] = 8'($urandom_range(60));
            thr_set[REG_LCR] = thr_set[REG_LNR] + 8'($urandom_range(40));
            thr_set[REG_LNC] = thr_set[REG_LCR] + 8'($urandom_range(40));
            thr_set[REG_UNC] = 8'(130 + $urandom_range(50));
            thr_set[REG_UCR] = thr_set[REG_UNC] + 8'($urandom_range(35));
            thr_set[REG_UNR] = 8'($urandom_range(255 - thr_set[REG_UCR]))
                               + thr_set[REG_UCR];
            hyst_set = {8'($urandom_range(12)), 8'($urandom_range(12))};
            en_set   = ($urandom_range(2) == 0) ? 24'($urandom) : 24'hFFFFFF;
         end
      endcase
      apply_config();
   endtask

   // readings cluster around a threshold and its hysteresis band
   function automatic logic [7:0] pick_reading();
      int t;
      int h;
      int v;

      if ($urandom_range(99) < 30) begin
         return 8'($urandom_range(255));
      end
      t = thr_set[3'($urandom_range(NUM_THR - 1))];
      h = ($urandom_range(1) == 1) ? int'(hyst_set[15:8]) : int'(hyst_set[7:0]);
      v = t + int'($urandom_range(2 * h + 4)) - (h + 2);
      if (v < 0) begin
         v = 0;
      end
      if (v > 255) begin
         v = 255;
      end
      return 8'(v);
   endfunction

   function automatic req_item_type random_item();
      flags_type fa;
      flags_type fd;
      logic      kind;

      kind = ($urandom_range(99) < 8) ? KIND_REARM : KIND_UPDATE;
      fa   = ($urandom_range(99) < 15) ? flags_type'($urandom) : '0;
      fd   = ($urandom_range(99) < 15) ? flags_type'($urandom) : '0;
      return make_item(kind, pick_reading(), $urandom_range(99) >= 8,
                       $urandom_range(99) >= 8, fa, fd);
   endfunction

   // a fixed count of random items, fresh settings now and then
   task automatic random_phase(int sender_pct, int receiver_pct);
      int           counted;
      req_item_type it;

      counted = 0;
      send_idle_pct = sender_pct;
      rsp_stall_pct = receiver_pct;
      new_settings();
      while (counted < ITEMS_PER_PHASE) begin
         it = random_item();
         send_item(it);
         counted++;
         if (counted % ITEMS_PER_SETTING == 0) begin
            new_settings();
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 35;
      rsp_stall_pct = 76;

      // directed: ordered thresholds, small hysteresis, every event enabled
      thr_set[REG_LNC] = 8'd60;
      thr_set[REG_LCR] = 8'd40;
      thr_set[REG_LNR] = 8'd20;
      thr_set[REG_UNC] = 8'd180;
      thr_set[REG_UCR] = 8'd200;
      thr_set[REG_UNR] = 8'd230;
      hyst_set = 16'h0505;
      en_set   = 24'hFFFFFF;
      apply_config();
      send_update(8'd128);
      send_update(8'd0);
      // threshold exactly, then the edge of the low hysteresis band and one past
      send_update(8'd60);
      send_update(8'd65);
      send_update(8'd66);
      send_update(8'd255);
      send_update(8'd180);
      // high hysteresis band edge, then one below
      send_update(8'd175);
      send_update(8'd174);
      // no reading, out of context, both
      send_item(make_item(KIND_UPDATE, 8'd0, 1'b0, 1'b1, '0, '0));
      send_item(make_item(KIND_UPDATE, 8'd255, 1'b1, 1'b0, '0, '0));
      send_item(make_item(KIND_UPDATE, 8'd128, 1'b0, 1'b0, '1, '1));
      // forced events on every bit regardless of state
      send_item(make_item(KIND_UPDATE, 8'd128, 1'b1, 1'b1, '1, '1));
      // rearm with every other field set, which it ignores
      send_item(make_item(KIND_REARM, 8'hFF, 1'b1, 1'b1, '1, '1));
      send_update(8'd128);

      // extreme thresholds, widest hysteresis, partial enables
      set_all_thresholds(8'hFF, 8'h00);
      hyst_set = 16'hFFFF;
      en_set   = 24'hA5C3_96;
      apply_config();
      send_update(8'd0);
      send_update(8'd255);
      send_item(make_item(KIND_UPDATE, 8'd128, 1'b1, 1'b1, '1, '0));

      // all events dropped while the flags still move
      set_all_thresholds(8'd60, 8'd180);
      hyst_set = 16'h0000;
      en_set   = 24'h000000;
      apply_config();
      send_update(8'd0);
      send_update(8'd255);
      // re-enable and read back the flags changed silently above
      en_set = 24'hFFFFFF;
      apply_config();
      send_update(8'd128);

      random_phase(35, 76);
      random_phase(76, 35);
      random_phase(0, 0);

      wait_idle();
      if (ledger.errors == 0) begin
         $display("threshold_sensor_event_engine_top_test: PASS");
      end else begin
         $display("threshold_sensor_event_engine_top_test: FAIL");
      end
      $finish;
   end

endmodule

// File: files.f
sv/tsee_pkg.sv
sv/threshold_sensor_event_engine_top.sv
bench/threshold_sensor_event_engine_top_test.sv
